>>> rtl/dual_ultrasonic_echo_timer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual ultrasonic echo timer core.
// Checks are active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DUAL_ULTRASONIC_ECHO_TIMER_CORE_DEFINES_SVH
`define DUAL_ULTRASONIC_ECHO_TIMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DUET_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("duet assertion failed")
`define DUET_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("duet assertion failed")
`else
`define DUET_ASSERT(label, prop)
`define DUET_ASSERT_NEVER(label, cond)
`endif

`endif

>>> rtl/duet_pkg.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic echo timer package
// Widths, state encodings, register indexes and shared structures.
// ----------------------------------------------------------------------------
package duet_pkg;

    localparam int TIME_BITS  = 16;
    localparam int COUNT_BITS = 8;

    typedef enum logic [1:0] {
        SENSOR_NONE   = 2'd0,
        SENSOR_FIRST  = 2'd1,
        SENSOR_SECOND = 2'd2
    } sensor_t;

    typedef enum logic [1:0] {
        PHASE_STOP = 2'd0,
        PHASE_RISE = 2'd1,
        PHASE_FALL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_INTERVAL      = 2'd0,
        CFG_ENABLE_FIRST  = 2'd1,
        CFG_ENABLE_SECOND = 2'd2
    } cfg_reg_t;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ECHO = 1'b1;

    typedef struct packed {
        logic [COUNT_BITS-1:0] interval_ticks;
        logic                  enable_first;
        logic                  enable_second;
    } cfg_t;

    typedef struct packed {
        logic                 command;
        logic                 echo_first;
        logic                 echo_second;
        logic [TIME_BITS-1:0] timer_value;
    } item_t;

    typedef struct packed {
        logic                 trigger_first;
        logic                 trigger_second;
        logic [TIME_BITS-1:0] reading_first;
        logic [TIME_BITS-1:0] reading_second;
        logic                 reading_valid;
        logic                 idle;
    } result_t;

endpackage

>>> rtl/duet_ctrl.sv
// ----------------------------------------------------------------------------
// Sensor sequencer and echo capture
// Holds the sensor selection, capture phase, interval countdown and readings,
// and updates them for one transaction per step.
// ----------------------------------------------------------------------------
`include "dual_ultrasonic_echo_timer_core_defines.svh"

module duet_ctrl
    import duet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    sensor_t               active_reg, active_next;
    phase_t                phase_reg, phase_next;
    logic [TIME_BITS-1:0]  rise_time_reg, rise_time_next;
    logic [COUNT_BITS-1:0] countdown_reg, countdown_next;
    logic [TIME_BITS-1:0]  stored_first_reg, stored_first_next;
    logic [TIME_BITS-1:0]  stored_second_reg, stored_second_next;

    function automatic logic is_enabled(sensor_t s, cfg_t c);
        logic en;
        en = 1'b0;
        if (s == SENSOR_FIRST)
        begin
            en = c.enable_first;
        end
        else if (s == SENSOR_SECOND)
        begin
            en = c.enable_second;
        end
        return en;
    endfunction

    always_comb
    begin
        sensor_t              pick;
        sensor_t              alt;
        logic                 level;
        logic [TIME_BITS-1:0] width;

        active_next        = active_reg;
        phase_next         = phase_reg;
        rise_time_next     = rise_time_reg;
        countdown_next     = countdown_reg;
        stored_first_next  = stored_first_reg;
        stored_second_next = stored_second_reg;
        result             = '0;

        pick  = (active_reg == SENSOR_FIRST) ? SENSOR_SECOND : SENSOR_FIRST;
        alt   = (pick == SENSOR_FIRST) ? SENSOR_SECOND : SENSOR_FIRST;
        level = (active_reg == SENSOR_FIRST) ? item.echo_first : item.echo_second;
        width = item.timer_value - rise_time_reg;

        if (item.command == CMD_TICK)
        begin
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 1'b1;
            end
            else
            begin
                if (is_enabled(pick, cfg))
                begin
                    active_next = pick;
                end
                else if (is_enabled(alt, cfg))
                begin
                    active_next = alt;
                end
                else
                begin
                    active_next = SENSOR_NONE;
                end
                if (active_next == SENSOR_NONE)
                begin
                    phase_next = PHASE_STOP;
                end
                else
                begin
                    phase_next = PHASE_RISE;
                    result.trigger_first  = (active_next == SENSOR_FIRST);
                    result.trigger_second = (active_next == SENSOR_SECOND);
                end
                countdown_next = cfg.interval_ticks;
            end
        end
        else if (active_reg != SENSOR_NONE && phase_reg != PHASE_STOP)
        begin
            case (phase_reg)
                PHASE_RISE:
                begin
                    if (level)
                    begin
                        rise_time_next = item.timer_value;
                        phase_next     = PHASE_FALL;
                    end
                end
                PHASE_FALL:
                begin
                    if (!level)
                    begin
                        if (active_reg == SENSOR_FIRST)
                        begin
                            stored_first_next = width;
                        end
                        else
                        begin
                            stored_second_next = width;
                        end
                        phase_next           = PHASE_STOP;
                        result.reading_valid = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PHASE_STOP;
                end
            endcase
        end

        result.reading_first  = stored_first_next;
        result.reading_second = stored_second_next;
        result.idle           = (active_next == SENSOR_NONE) || (phase_next == PHASE_STOP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= SENSOR_NONE;
            phase_reg         <= PHASE_STOP;
            rise_time_reg     <= '0;
            countdown_reg     <= '0;
            stored_first_reg  <= '0;
            stored_second_reg <= '0;
        end
        else if (step)
        begin
            active_reg        <= active_next;
            phase_reg         <= phase_next;
            rise_time_reg     <= rise_time_next;
            countdown_reg     <= countdown_next;
            stored_first_reg  <= stored_first_next;
            stored_second_reg <= stored_second_next;
        end
    end

    `DUET_ASSERT(a_trigger_arms, step && (result.trigger_first || result.trigger_second) |=> phase_reg == PHASE_RISE);
    `DUET_ASSERT(a_reading_stops, step && result.reading_valid |=> phase_reg == PHASE_STOP);
    `DUET_ASSERT_NEVER(a_fall_needs_sensor, phase_reg == PHASE_FALL && active_reg == SENSOR_NONE);
    `DUET_ASSERT(a_readings_hold, !step |=> $stable(stored_first_reg) && $stable(stored_second_reg));

endmodule

>>> rtl/dual_ultrasonic_echo_timer_core.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic echo timer core
// Alternates trigger pulses between two ultrasonic sensors and measures the
// width of each echo pulse from capture timer values.
// ----------------------------------------------------------------------------
// Each input transaction is either an interval tick or an echo pin change and
// produces exactly one result transaction. The core accepts one transaction
// per clock cycle while the result is not stalled; a transaction passes
// through an input register, the sequencer logic that updates the sensor state,
// and a result register, and its result is offered from the result register.
// A stalled result holds the pipeline and raises in_stall once the input
// register is also occupied. Configuration writes are always accepted and
// should only be made while no transaction is in flight.

module dual_ultrasonic_echo_timer_core
    import duet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic                  echo_first,
    input  logic                  echo_second,
    input  logic [TIME_BITS-1:0]  timer_value,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  trigger_first,
    output logic                  trigger_second,
    output logic [TIME_BITS-1:0]  reading_first,
    output logic [TIME_BITS-1:0]  reading_second,
    output logic                  reading_valid,
    output logic                  idle,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [COUNT_BITS-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;
    logic    step;
    logic    in_accept;

    assign advance   = !out_valid_reg || !out_stall;
    assign step      = stage_valid_reg && advance;
    assign in_stall  = stage_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ticks <= COUNT_BITS'(20);
            cfg_reg.enable_first   <= 1'b1;
            cfg_reg.enable_second  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_INTERVAL:      cfg_reg.interval_ticks <= cfg_data;
                CFG_ENABLE_FIRST:  cfg_reg.enable_first   <= cfg_data[0];
                CFG_ENABLE_SECOND: cfg_reg.enable_second  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_item_reg <= '{command, echo_first, echo_second, timer_value};
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    duet_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid      = out_valid_reg;
    assign trigger_first  = out_reg.trigger_first;
    assign trigger_second = out_reg.trigger_second;
    assign reading_first  = out_reg.reading_first;
    assign reading_second = out_reg.reading_second;
    assign reading_valid  = out_reg.reading_valid;
    assign idle           = out_reg.idle;

endmodule
